// ===== rtl/thai_glyph_position_adjust_unit_macros.svh =====
// assertion macros for the thai glyph position adjust unit
`ifndef THAI_GLYPH_POSITION_ADJUST_UNIT_MACROS_SVH
`define THAI_GLYPH_POSITION_ADJUST_UNIT_MACROS_SVH

// checked only while out of reset
`define TGPA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// checked at every edge, reset included
`define TGPA_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== rtl/tgpa_pkg.sv =====
// types, constants and glyph tables shared by the glyph position adjust unit
`timescale 1ns / 1ps

package tgpa_pkg;

  localparam int unsigned CmdQueueDepth = 4;

  localparam logic [7:0] SaraAm   = 8'hd3;
  localparam logic [7:0] SaraAa   = 8'hd2;
  localparam logic [7:0] Nikhahit = 8'hed;
  localparam logic [7:0] YoYing   = 8'had;
  localparam logic [7:0] DoChada  = 8'hae;
  localparam logic [7:0] ToPatak  = 8'haf;
  localparam logic [7:0] ThoThan  = 8'hb0;
  localparam logic [7:0] YoYingPlain = 8'h90;
  localparam logic [7:0] TopFirst   = 8'he8;
  localparam logic [7:0] TopLast    = 8'hec;
  localparam logic [7:0] BelowFirst = 8'hd8;
  localparam logic [7:0] BelowLast  = 8'hda;
  localparam logic [7:0] BelowLowBase = 8'hfc;

  // one accepted request turns into up to three result bytes
  typedef struct packed {
    logic [1:0]      cnt;
    logic            last;
    logic [2:0][7:0] bytes;
  } cmd_t;

  function automatic logic long_tail(input logic [7:0] c);
    return (c == 8'hbb) || (c == 8'hbd) || (c == 8'hbf) || (c == 8'hcc);
  endfunction

  function automatic logic is_top(input logic [7:0] c);
    return (c >= TopFirst) && (c <= TopLast);
  endfunction

  function automatic logic [2:0] top_idx(input logic [7:0] c);
    logic [7:0] d;
    d = c - TopFirst;
    return d[2:0];
  endfunction

  function automatic logic is_below(input logic [7:0] c);
    return (c >= BelowFirst) && (c <= BelowLast);
  endfunction

  function automatic logic [7:0] below_low(input logic [7:0] c);
    logic [7:0] d;
    d = c - BelowFirst;
    return BelowLowBase + {6'd0, d[1:0]};
  endfunction

  function automatic logic is_above(input logic [7:0] c);
    return (c == 8'hd1) || (c == 8'hd4) || (c == 8'hd5) || (c == 8'hd6) ||
           (c == 8'hd7) || (c == 8'he7) || (c == 8'hed);
  endfunction

  function automatic logic [7:0] above_left(input logic w, input logic [7:0] c);
    logic [7:0] r;
    unique case (c)
      8'hd1:   r = w ? 8'h98 : 8'h92;
      8'hd4:   r = w ? 8'h81 : 8'h94;
      8'hd5:   r = w ? 8'h82 : 8'h95;
      8'hd6:   r = w ? 8'h83 : 8'h96;
      8'hd7:   r = w ? 8'h84 : 8'h97;
      8'he7:   r = w ? 8'h9a : 8'h93;
      8'hed:   r = w ? 8'h99 : 8'h8f;
      default: r = c;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] top_low(input logic w, input logic [2:0] i);
    return (w ? 8'h8b : 8'h88) + {5'd0, i};
  endfunction

  function automatic logic [7:0] top_low_left(input logic w, input logic [2:0] i);
    return (w ? 8'h86 : 8'h83) + {5'd0, i};
  endfunction

  function automatic logic [7:0] top_left(input logic w, input logic [2:0] i);
    return (w ? 8'h9b : 8'h98) + {5'd0, i};
  endfunction

  function automatic logic [7:0] left_nikhahit(input logic w);
    return w ? 8'h99 : 8'h8f;
  endfunction

  function automatic logic [7:0] tho_than_plain(input logic w);
    return w ? 8'h80 : 8'h9f;
  endfunction

endpackage

// ===== rtl/tgpa_front.sv =====
// front end: string context, glyph classification and result command build
`timescale 1ns / 1ps

module tgpa_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  input  logic             req_i,
  input  logic [7:0]       in_byte_i,
  input  logic             in_last_i,
  output logic             cmd_push_o,
  output tgpa_pkg::cmd_t   cmd_o
);
  import tgpa_pkg::*;

  logic       win_q;
  logic [7:0] prev_q, prev_d;
  logic [7:0] prev2_q, prev2_d;
  logic [1:0] pos_q, pos_d;
  logic [7:0] pend_q, pend_d;
  logic       pend_v_q, pend_v_d;
  logic       pend_low_q, pend_low_d;

  logic [7:0] pend;
  logic [7:0] fresh;
  logic       extra;
  logic       lowerable;
  logic       pos1, pos2;
  logic [1:0] n_all;
  logic [7:0] s0, s1;

  always_comb begin
    pend      = pend_q;
    fresh     = in_byte_i;
    extra     = 1'b0;
    lowerable = 1'b0;
    pos1      = (pos_q != 2'd0);
    pos2      = pos_q[1];

    // held tone mark drops unless sara am follows
    if (pend_v_q && pend_low_q && (in_byte_i != SaraAm) && is_top(pend_q)) begin
      pend = top_low(win_q, top_idx(pend_q));
    end

    if (in_byte_i == SaraAm) begin
      extra = 1'b1;
      fresh = Nikhahit;
      if (pos1) begin
        if (long_tail(prev_q)) begin
          fresh = left_nikhahit(win_q);
        end else if (is_top(prev_q)) begin
          if (pos2) begin
            if (long_tail(prev2_q)) begin
              fresh = top_left(win_q, top_idx(prev_q));
              pend  = left_nikhahit(win_q);
            end else begin
              fresh = prev_q;
              pend  = Nikhahit;
            end
          end else begin
            fresh = SaraAm;
          end
        end
      end
    end else if (is_top(in_byte_i)) begin
      if (pos1) begin
        if (long_tail(prev_q)) begin
          fresh = top_low_left(win_q, top_idx(in_byte_i));
        end else if (is_above(prev_q)) begin
          if (pos2 && long_tail(prev2_q)) begin
            fresh = top_left(win_q, top_idx(in_byte_i));
          end
        end else if (is_below(prev_q)) begin
          if (pos2) begin
            fresh = long_tail(prev2_q) ? top_low_left(win_q, top_idx(in_byte_i))
                                       : top_low(win_q, top_idx(in_byte_i));
          end
        end else begin
          lowerable = 1'b1;
        end
      end
    end else if (is_above(in_byte_i)) begin
      if (pos1 && long_tail(prev_q)) begin
        fresh = above_left(win_q, in_byte_i);
      end
    end else if (is_below(in_byte_i)) begin
      if (pos1) begin
        if (prev_q == YoYing) begin
          pend = YoYingPlain;
        end else if ((prev_q == DoChada) || (prev_q == ToPatak)) begin
          fresh = below_low(in_byte_i);
        end else if (prev_q == ThoThan) begin
          pend = tho_than_plain(win_q);
        end
      end
    end

    // end of string lowers a trailing tone mark at once
    if (in_last_i && lowerable) begin
      fresh     = top_low(win_q, top_idx(in_byte_i));
      lowerable = 1'b0;
    end
  end

  assign n_all = 2'd1 + {1'b0, pend_v_q} + {1'b0, extra};
  assign s0    = pend_v_q ? pend : fresh;
  assign s1    = pend_v_q ? fresh : SaraAa;

  always_comb begin
    cmd_o.bytes = {SaraAa, s1, s0};
    cmd_o.last  = in_last_i;
    cmd_o.cnt   = in_last_i ? n_all : (n_all - 2'd1);
  end

  assign cmd_push_o = req_i && (cmd_o.cnt != 2'd0);

  always_comb begin
    prev_d     = prev_q;
    prev2_d    = prev2_q;
    pos_d      = pos_q;
    pend_d     = pend_q;
    pend_v_d   = pend_v_q;
    pend_low_d = pend_low_q;
    if (req_i) begin
      if (in_last_i) begin
        prev_d     = '0;
        prev2_d    = '0;
        pos_d      = '0;
        pend_d     = '0;
        pend_v_d   = 1'b0;
        pend_low_d = 1'b0;
      end else begin
        prev_d     = in_byte_i;
        prev2_d    = prev_q;
        pos_d      = (pos_q == 2'd3) ? pos_q : (pos_q + 2'd1);
        pend_d     = extra ? SaraAa : fresh;
        pend_v_d   = 1'b1;
        pend_low_d = lowerable && !extra;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q      <= 1'b0;
      prev_q     <= '0;
      prev2_q    <= '0;
      pos_q      <= '0;
      pend_q     <= '0;
      pend_v_q   <= 1'b0;
      pend_low_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        win_q <= cfg_wdata_i;
      end
      prev_q     <= prev_d;
      prev2_q    <= prev2_d;
      pos_q      <= pos_d;
      pend_q     <= pend_d;
      pend_v_q   <= pend_v_d;
      pend_low_q <= pend_low_d;
    end
  end

endmodule

// ===== rtl/tgpa_cmd_queue.sv =====
// short command queue between the front end and the result serializer
`timescale 1ns / 1ps

module tgpa_cmd_queue #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tgpa_pkg::cmd_t wdata_i,
  input  logic           pop_i,
  output tgpa_pkg::cmd_t rdata_o,
  output logic           empty_o,
  output logic           full_o
);
  import tgpa_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  cmd_t            mem_q [Depth];
  logic [PtrW-1:0] wptr_q, wptr_d;
  logic [PtrW-1:0] rptr_q, rptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            do_push, do_pop;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = mem_q[rptr_q];

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    cnt_d  = cnt_q;
    if (do_push) begin
      wptr_d = (wptr_q == PtrW'(Depth - 1)) ? '0 : (wptr_q + PtrW'(1));
    end
    if (do_pop) begin
      rptr_d = (rptr_q == PtrW'(Depth - 1)) ? '0 : (rptr_q + PtrW'(1));
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== rtl/tgpa_back.sv =====
// back end: walks each command one byte a cycle into the result register while the receiver keeps popping
`timescale 1ns / 1ps

module tgpa_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  tgpa_pkg::cmd_t cmd_i,
  input  logic           cmd_empty_i,
  output logic           cmd_pop_o,
  input  logic           pop_i,
  output logic           empty_o,
  output logic [7:0]     out_byte_o,
  output logic           out_last_o
);
  import tgpa_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic       out_v_q, out_v_d;
  logic [7:0] byte_q;
  logic       last_q;
  logic       load;
  logic       final_slot;
  logic [7:0] sel_byte;

  assign load       = !cmd_empty_i && (!out_v_q || pop_i);
  assign final_slot = (idx_q == (cmd_i.cnt - 2'd1));
  assign cmd_pop_o  = load && final_slot;

  always_comb begin
    unique case (idx_q)
      2'd0:    sel_byte = cmd_i.bytes[0];
      2'd1:    sel_byte = cmd_i.bytes[1];
      2'd2:    sel_byte = cmd_i.bytes[2];
      default: sel_byte = cmd_i.bytes[0];
    endcase
  end

  always_comb begin
    idx_d   = idx_q;
    out_v_d = out_v_q;
    if (load) begin
      out_v_d = 1'b1;
      idx_d   = final_slot ? 2'd0 : (idx_q + 2'd1);
    end else if (pop_i) begin
      out_v_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= sel_byte;
      last_q <= cmd_i.last && final_slot;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      idx_q   <= idx_d;
      out_v_q <= out_v_d;
    end
  end

  assign empty_o    = !out_v_q;
  assign out_byte_o = byte_q;
  assign out_last_o = last_q;

endmodule

// ===== rtl/thai_glyph_position_adjust_unit.sv =====
// top level of the thai glyph position adjust unit
//
// input side is a queue: a tis-620 byte with its end-of-string flag is taken
// at an edge where push is high and full is low. result side is a queue too:
// out_byte_o/out_last_o hold the oldest result while empty is low and it is
// taken at an edge where pop is high. cfg_we_i writes cfg_wdata_i into the
// glyph set select (1 windows codes, 0 mac codes); the user must write it
// only while the unit is idle, the block itself does not enforce that.
// each request yields zero to three result bytes; the last byte of a string
// is held back until the next byte arrives or the string ends.
// throughput: one request per cycle into the front end while full is low,
// one result per cycle out of the serializer while pop is held and a command
// is queued; the command queue absorbs bursts. reset clears the string
// context, the glyph select and the queue and empties the result register.
// when the receiver stalls the result holds, the queue fills and full rises;
// nothing is dropped.
`timescale 1ns / 1ps

module thai_glyph_position_adjust_unit #(
  parameter int unsigned CmdDepth = tgpa_pkg::CmdQueueDepth
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic       cfg_wdata_i,
  input  logic       push,
  output logic       full,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);
  import tgpa_pkg::*;

  logic req;
  logic cmd_push;
  cmd_t cmd_in;
  cmd_t cmd_head;
  logic cmd_empty;
  logic cmd_full;
  logic cmd_pop;

  assign full = cmd_full;
  assign req  = push && !cmd_full;

  tgpa_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .req_i       (req),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .cmd_push_o  (cmd_push),
    .cmd_o       (cmd_in)
  );

  tgpa_cmd_queue #(
    .Depth (CmdDepth)
  ) u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (cmd_push),
    .wdata_i (cmd_in),
    .pop_i   (cmd_pop),
    .rdata_o (cmd_head),
    .empty_o (cmd_empty),
    .full_o  (cmd_full)
  );

  tgpa_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd_head),
    .cmd_empty_i (cmd_empty),
    .cmd_pop_o   (cmd_pop),
    .pop_i       (pop),
    .empty_o     (empty),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

endmodule

// ===== rtl/tgpa_checker.sv =====
// port level checks for the thai glyph position adjust unit, with its bind
`timescale 1ns / 1ps
`include "thai_glyph_position_adjust_unit_macros.svh"

module tgpa_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       push,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_byte_o,
  input logic       out_last_o
);

  // a stalled result stays put
  `TGPA_ASSERT(a_hold, (!empty && !pop) |=> (!empty && $stable(out_byte_o) && $stable(out_last_o)), "result changed while stalled")

  // reset leaves both sides idle
  `TGPA_ASSERT_ALWAYS(a_rst_idle, !rst_ni |-> (empty && !full), "not idle in reset")

  // the queue only fills after an accepted request
  `TGPA_ASSERT(a_full_src, $rose(full) |-> $past(push && !full), "full without request")

endmodule

bind thai_glyph_position_adjust_unit tgpa_checker u_tgpa_checker (.*);

// ===== dv/tgpa_dv_pkg.sv =====
// glyph predictor and result checker for the thai glyph position adjust unit test
`timescale 1ns / 1ps

package tgpa_dv_pkg;

  import tgpa_pkg::*;

  class glyph_scoreboard;

    logic        win_glyphs = 1'b0;
    logic [7:0]  prev_byte = '0;
    logic [7:0]  prev2_byte = '0;
    logic [1:0]  seen = '0;
    logic [7:0]  held_byte = '0;
    logic        held_valid = 1'b0;
    logic        held_lowerable = 1'b0;
    // {last, byte} of every result still owed by the block
    logic [8:0]  expected_glyphs[$];
    int          failures = 0;
    int          requests_noted = 0;
    int          results_checked = 0;

    function void set_glyph_set(logic w);
      win_glyphs = w;
    endfunction

    function int outstanding();
      return expected_glyphs.size();
    endfunction

    function logic long_tail(logic [7:0] c);
      return c == 8'hbb || c == 8'hbd || c == 8'hbf || c == 8'hcc;
    endfunction

    function int tone_slot(logic [7:0] c);
      return (c >= TopFirst && c <= TopLast) ? int'(c - TopFirst) : -1;
    endfunction

    function logic upper_vowel(logic [7:0] c);
      return c == 8'hd1 || c == 8'hd4 || c == 8'hd5 || c == 8'hd6 || c == 8'hd7 ||
             c == 8'he7 || c == Nikhahit;
    endfunction

    function logic lower_vowel(logic [7:0] c);
      return c >= BelowFirst && c <= BelowLast;
    endfunction

    function logic [7:0] lowered_tone(int i);
      return (win_glyphs ? 8'h8b : 8'h88) + 8'(i);
    endfunction

    function logic [7:0] lowered_left_tone(int i);
      return (win_glyphs ? 8'h86 : 8'h83) + 8'(i);
    endfunction

    function logic [7:0] left_tone(int i);
      return (win_glyphs ? 8'h9b : 8'h98) + 8'(i);
    endfunction

    function logic [7:0] left_nikhahit();
      return win_glyphs ? 8'h99 : 8'h8f;
    endfunction

    function logic [7:0] left_upper(logic [7:0] c);
      logic [7:0] r;
      case (c)
        8'hd1:   r = win_glyphs ? 8'h98 : 8'h92;
        8'hd4:   r = win_glyphs ? 8'h81 : 8'h94;
        8'hd5:   r = win_glyphs ? 8'h82 : 8'h95;
        8'hd6:   r = win_glyphs ? 8'h83 : 8'h96;
        8'hd7:   r = win_glyphs ? 8'h84 : 8'h97;
        8'he7:   r = win_glyphs ? 8'h9a : 8'h93;
        default: r = win_glyphs ? 8'h99 : 8'h8f;
      endcase
      return r;
    endfunction

    // works out the glyphs one accepted request releases
    function void adjust_glyphs(logic [7:0] b, logic last);
      logic [7:0] glyphs[$];
      logic [7:0] fresh;
      logic       extra_aa;
      logic       lowerable;
      int         ti;
      int         tp;
      fresh = b;
      extra_aa = 1'b0;
      lowerable = 1'b0;
      requests_noted++;
      if (held_valid && held_lowerable && b != SaraAm) begin
        ti = tone_slot(held_byte);
        if (ti >= 0) held_byte = lowered_tone(ti);
      end
      ti = tone_slot(b);
      if (b == SaraAm) begin
        extra_aa = 1'b1;
        fresh = Nikhahit;
        if (seen >= 1) begin
          tp = tone_slot(prev_byte);
          if (long_tail(prev_byte)) begin
            fresh = left_nikhahit();
          end else if (tp >= 0) begin
            if (seen >= 2) begin
              if (long_tail(prev2_byte)) begin
                fresh = left_tone(tp);
                held_byte = left_nikhahit();
              end else begin
                fresh = prev_byte;
                held_byte = Nikhahit;
              end
            end else begin
              fresh = SaraAm;
            end
          end
        end
      end else if (ti >= 0) begin
        if (seen >= 1) begin
          if (long_tail(prev_byte)) begin
            fresh = lowered_left_tone(ti);
          end else if (upper_vowel(prev_byte)) begin
            if (seen >= 2 && long_tail(prev2_byte)) fresh = left_tone(ti);
          end else if (lower_vowel(prev_byte)) begin
            if (seen >= 2) fresh = long_tail(prev2_byte) ? lowered_left_tone(ti) : lowered_tone(ti);
          end else begin
            lowerable = 1'b1;
          end
        end
      end else if (upper_vowel(b)) begin
        if (seen >= 1 && long_tail(prev_byte)) fresh = left_upper(b);
      end else if (lower_vowel(b)) begin
        if (seen >= 1) begin
          if (prev_byte == YoYing) begin
            held_byte = YoYingPlain;
          end else if (prev_byte == DoChada || prev_byte == ToPatak) begin
            fresh = BelowLowBase + (b - BelowFirst);
          end else if (prev_byte == ThoThan) begin
            held_byte = win_glyphs ? 8'h80 : 8'h9f;
          end
        end
      end

      if (held_valid) glyphs.push_back(held_byte);
      if (last && lowerable) begin
        fresh = lowered_tone(ti);
        lowerable = 1'b0;
      end
      glyphs.push_back(fresh);
      if (extra_aa) glyphs.push_back(SaraAa);

      if (last) begin
        foreach (glyphs[k]) expected_glyphs.push_back({k == glyphs.size() - 1, glyphs[k]});
        prev_byte = '0;
        prev2_byte = '0;
        seen = '0;
        held_byte = '0;
        held_valid = 1'b0;
        held_lowerable = 1'b0;
      end else begin
        for (int k = 0; k < glyphs.size() - 1; k++) expected_glyphs.push_back({1'b0, glyphs[k]});
        held_byte = glyphs[glyphs.size() - 1];
        held_valid = 1'b1;
        held_lowerable = lowerable && !extra_aa;
        prev2_byte = prev_byte;
        prev_byte = b;
        if (seen != 2'd3) seen++;
      end
    endfunction

    function void check_result(logic [7:0] b, logic last);
      logic [8:0] want;
      results_checked++;
      if (expected_glyphs.size() == 0) begin
        if (failures < 10) $display("unexpected result: byte %02h last %0b", b, last);
        failures++;
      end else begin
        want = expected_glyphs.pop_front();
        if (want[7:0] !== b || want[8] !== last) begin
          if (failures < 10) begin
            $display("mismatch at result %0d: expected byte %02h last %0b, got byte %02h last %0b",
                     results_checked, want[7:0], want[8], b, last);
          end
          failures++;
        end
      end
    endfunction

  endclass

endpackage

// ===== dv/thai_glyph_position_adjust_unit_test.sv =====
// top of the thai glyph position adjust unit test: stimulus, handshakes and final check
`timescale 1ns / 1ps

module thai_glyph_position_adjust_unit_test;

  import tgpa_pkg::*;
  import tgpa_dv_pkg::*;

  localparam int CycleLimit   = 400000;
  localparam int SettleCycles = 8;
  localparam int PhaseItems   = 100;
  localparam int Phases       = 4;

  // {last, byte}
  localparam logic [8:0] DirectedSeq [26] = '{
    9'h101,
    9'h0e8, 9'h1d3,
    9'h0bb, 9'h0e9, 9'h1d3,
    9'h0a1, 9'h0ea, 9'h1d3,
    9'h0bd, 9'h0d4, 9'h1e8,
    9'h0a1, 9'h0e9, 9'h1ff,
    9'h0a1, 9'h1eb,
    9'h0ad, 9'h1d8,
    9'h0b0, 9'h1d9,
    9'h0ae, 9'h1da,
    9'h0bf, 9'h0d9, 9'h1ec
  };
  localparam logic [7:0] LongTails [4]   = '{8'hbb, 8'hbd, 8'hbf, 8'hcc};
  localparam logic [7:0] ClearTails [4]  = '{YoYing, DoChada, ToPatak, ThoThan};
  localparam logic [7:0] UpperVowels [7] = '{8'hd1, 8'hd4, 8'hd5, 8'hd6, 8'hd7, 8'he7, 8'hed};

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b1;
  logic       cfg_we_i = 1'b0;
  logic       cfg_wdata_i = 1'b0;
  logic       push = 1'b0;
  logic       full;
  logic [7:0] in_byte_i = 8'h01;
  logic       in_last_i = 1'b0;
  logic       empty;
  logic       pop = 1'b0;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  glyph_scoreboard sb = new();
  logic            no_idle = 1'b0;
  int              cycle_count = 0;
  int              items_sent = 0;

  thai_glyph_position_adjust_unit u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .push        (push),
    .full        (full),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .empty       (empty),
    .pop         (pop),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("timeout after %0d cycles, %0d results owed", cycle_count, sb.outstanding());
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_request(logic [7:0] b, logic last);
    int  gap;
    logic taken;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    in_byte_i <= b;
    in_last_i <= last;
    do begin
      @(negedge clk_i);
      taken = !full;
      @(posedge clk_i);
    end while (!taken);
    sb.adjust_glyphs(b, last);
    items_sent++;
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic program_glyph_set(logic w);
    drain_results();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.set_glyph_set(w);
  endtask

  function automatic logic [7:0] any_tone();
    return TopFirst + 8'($urandom_range(0, 4));
  endfunction

  // mostly well-formed syllables, some noise and a stray leading tone mark
  task automatic send_random_string();
    logic [7:0] text[$];
    int         kind;
    logic       mark;
    if ($urandom_range(0, 9) == 0) text.push_back(any_tone());
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 9) == 0) begin
        text.push_back(8'($urandom_range(1, 255)));
      end else begin
        kind = $urandom_range(0, 9);
        if (kind < 3) text.push_back(LongTails[$urandom_range(0, 3)]);
        else if (kind < 5) text.push_back(ClearTails[$urandom_range(0, 3)]);
        else text.push_back(8'ha1 + 8'($urandom_range(0, 45)));
        kind = $urandom_range(0, 9);
        mark = 1'b0;
        if (kind == 3 || kind == 4) begin
          text.push_back(UpperVowels[$urandom_range(0, 6)]);
          mark = $urandom_range(0, 1);
        end else if (kind == 5 || kind == 6) begin
          text.push_back(BelowFirst + 8'($urandom_range(0, 2)));
          mark = $urandom_range(0, 1);
        end else if (kind >= 8) begin
          mark = 1'b1;
        end
        if (mark) begin
          text.push_back(any_tone());
          if ($urandom_range(0, 2) == 0) text.push_back(SaraAm);
        end else if (kind == 7) begin
          text.push_back(SaraAm);
        end
      end
    end
    foreach (text[i]) send_request(text[i], i == text.size() - 1);
  endtask

  initial begin : result_side
    int   gap;
    logic taken;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        pop <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      pop <= 1'b1;
      do begin
        @(negedge clk_i);
        taken = !empty;
        if (taken) sb.check_result(out_byte_o, out_last_o);
        @(posedge clk_i);
      end while (!taken);
    end
  end

  initial begin : request_side
    int phase_start;
    rst_ni <= 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedSeq[i]) send_request(DirectedSeq[i][7:0], DirectedSeq[i][8]);

    for (int phase = 0; phase < Phases; phase++) begin
      program_glyph_set(phase % 2 == 0);
      no_idle = (phase == 2);
      phase_start = items_sent;
      while (items_sent - phase_start < PhaseItems) send_random_string();
    end
    no_idle = 1'b0;
    drain_results();

    $display("%0d requests and %0d results checked in %0d cycles, mac and windows glyph sets",
             items_sent, sb.results_checked, cycle_count);
    $display("directed syllable cases plus random strings with and without idle cycles");
    if (sb.failures == 0 && sb.outstanding() == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches, %0d results owed", sb.failures, sb.outstanding());
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/tgpa_pkg.sv
rtl/tgpa_front.sv
rtl/tgpa_cmd_queue.sv
rtl/tgpa_back.sv
rtl/thai_glyph_position_adjust_unit.sv
rtl/tgpa_checker.sv
dv/tgpa_dv_pkg.sv
dv/thai_glyph_position_adjust_unit_test.sv
